@@ hdl/lfpe_pkg.sv @@
// lfpe_pkg: shared constants, codes and controller/datapath command types
// for the led fade program engine. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lfpe_pkg;

  localparam int unsigned LED_COUNT_DEF = 64;
  localparam int unsigned CHANNELS_DEF  = 3;

  localparam int unsigned ACT_W  = 2;
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned PROG_W = 2;
  localparam int unsigned LVL_W  = 8;
  // number of colour fields carried on the channels
  localparam int unsigned FIELD_CH = 3;

  typedef enum logic [ACT_W-1:0] {
    ACT_SET  = 2'd0,
    ACT_TICK = 2'd1,
    ACT_READ = 2'd2
  } action_e;

  typedef enum logic [PROG_W-1:0] {
    PROG_CONST  = 2'd0,
    PROG_LINEAR = 2'd1,
    PROG_LOOP   = 2'd2,
    PROG_HOLD   = 2'd3
  } prog_e;

  // controller to datapath
  typedef struct packed {
    logic capture;   // latch the item just transferred
    logic cnt_clr;   // restart the sweep counter
    logic sweep_rd;  // read the row at the sweep counter and advance
    logic led_rd;    // read the row of the named led
    logic finish;    // commit a set and load the result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic item_tick; // offered item is a tick
    logic cnt_last;  // sweep counter is at the last led
    logic out_free;  // result register can take a new result
  } stat_t;

endpackage : lfpe_pkg

`default_nettype wire

@@ hdl/lfpe_if.sv @@
// lfpe_in_if / lfpe_out_if: valid/ready channels carrying one item and one result.
// Depends on lfpe_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface lfpe_in_if;
  import lfpe_pkg::*;
  logic                valid;
  logic                ready;
  logic [ACT_W-1:0]    action;
  logic [IDX_W-1:0]    led_index;
  logic [PROG_W-1:0]   program_req;
  logic [LVL_W-1:0]    red_start;
  logic [LVL_W-1:0]    green_start;
  logic [LVL_W-1:0]    blue_start;

  modport source (output valid, action, led_index, program_req, red_start, green_start,
                  blue_start, input ready);
  modport sink   (input valid, action, led_index, program_req, red_start, green_start,
                  blue_start, output ready);
endinterface : lfpe_in_if

interface lfpe_out_if;
  import lfpe_pkg::*;
  logic                valid;
  logic                ready;
  logic [LVL_W-1:0]    red_now;
  logic [LVL_W-1:0]    green_now;
  logic [LVL_W-1:0]    blue_now;
  logic [PROG_W-1:0]   program_now;

  modport source (output valid, red_now, green_now, blue_now, program_now, input ready);
  modport sink   (input valid, red_now, green_now, blue_now, program_now, output ready);
endinterface : lfpe_out_if

`default_nettype wire

@@ hdl/lfpe_ctrl.sv @@
// lfpe_ctrl: sequencing state machine of the led fade program engine.
// Depends on lfpe_pkg for the command and status types.
`timescale 1ns / 1ps
`default_nettype none

module lfpe_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire lfpe_pkg::stat_t stat_i,
  output lfpe_pkg::cmd_t      cmd_o
);
  import lfpe_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_TICK     = 5'b00010,
    S_TICK_END = 5'b00100,
    S_LOOK     = 5'b01000,
    S_DONE     = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if (stat_i.item_tick) begin
            cmd_o.cnt_clr = 1'b1;
            state_d       = S_TICK;
          end else begin
            state_d = S_LOOK;
          end
        end
      end
      S_TICK: begin
        cmd_o.sweep_rd = 1'b1;
        if (stat_i.cnt_last) state_d = S_TICK_END;
      end
      // last write-back of the sweep lands here
      S_TICK_END: state_d = S_LOOK;
      S_LOOK: begin
        cmd_o.led_rd = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule : lfpe_ctrl

`default_nettype wire

@@ hdl/lfpe_dp.sv @@
// lfpe_dp: led state memories, sweep counter, decay/set logic and result register.
// Depends on lfpe_pkg for widths, codes and the command and status types.
`timescale 1ns / 1ps
`default_nettype none

module lfpe_dp #(
  parameter int unsigned LED_COUNT = lfpe_pkg::LED_COUNT_DEF,
  parameter int unsigned CHANNELS  = lfpe_pkg::CHANNELS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire lfpe_pkg::cmd_t                cmd_i,
  output lfpe_pkg::stat_t                    stat_o,
  input  wire logic [lfpe_pkg::ACT_W-1:0]    action_i,
  input  wire logic [lfpe_pkg::IDX_W-1:0]    led_index_i,
  input  wire logic [lfpe_pkg::PROG_W-1:0]   program_req_i,
  input  wire logic [lfpe_pkg::LVL_W-1:0]    red_start_i,
  input  wire logic [lfpe_pkg::LVL_W-1:0]    green_start_i,
  input  wire logic [lfpe_pkg::LVL_W-1:0]    blue_start_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [lfpe_pkg::LVL_W-1:0]         red_now_o,
  output logic [lfpe_pkg::LVL_W-1:0]         green_now_o,
  output logic [lfpe_pkg::LVL_W-1:0]         blue_now_o,
  output logic [lfpe_pkg::PROG_W-1:0]        program_now_o
);
  import lfpe_pkg::*;

  localparam int unsigned AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int unsigned IW = ((AW > IDX_W) ? AW : IDX_W) + 1;

  typedef logic [CHANNELS-1:0][LVL_W-1:0] lvl_vec_t;

  // captured item
  logic [ACT_W-1:0]              act_q;
  logic [IDX_W-1:0]              led_q;
  logic [PROG_W-1:0]             prog_q;
  logic [FIELD_CH-1:0][LVL_W-1:0] start_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q   <= action_i;
      led_q   <= led_index_i;
      prog_q  <= program_req_i;
      start_q <= {blue_start_i, green_start_i, red_start_i};
    end
  end

  logic [IW-1:0] led_w;
  logic [AW-1:0] led_addr;
  logic          idx_ok;
  assign led_w    = IW'(led_q);
  assign led_addr = led_w[AW-1:0];
  assign idx_ok   = led_w < IW'(LED_COUNT);

  // sweep counter and one-stage read/write-back pipeline
  logic [AW-1:0] cnt_q;
  logic [AW-1:0] wb_addr_q;
  logic          wb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wb_q  <= 1'b0;
    end else begin
      wb_q <= cmd_i.sweep_rd;
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.sweep_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep_rd) wb_addr_q <= cnt_q;
  end

  // memories and per-led valid bits; a row never written reads as zero
  lvl_vec_t          color_mem  [LED_COUNT];
  lvl_vec_t          reload_mem [LED_COUNT];
  logic [PROG_W-1:0] prog_mem   [LED_COUNT];
  logic [LED_COUNT-1:0] row_vld_q;

  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  lvl_vec_t          rd_col_q, rd_rel_q;
  logic [PROG_W-1:0] rd_prog_q;
  logic              rd_vld_q;

  assign rd_en   = cmd_i.sweep_rd | cmd_i.led_rd;
  assign rd_addr = cmd_i.sweep_rd ? cnt_q : led_addr;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_col_q  <= color_mem[rd_addr];
      rd_rel_q  <= reload_mem[rd_addr];
      rd_prog_q <= prog_mem[rd_addr];
      rd_vld_q  <= row_vld_q[rd_addr];
    end
  end

  lvl_vec_t          row_col, row_rel;
  logic [PROG_W-1:0] row_prog;
  assign row_col  = rd_vld_q ? rd_col_q  : '0;
  assign row_rel  = rd_vld_q ? rd_rel_q  : '0;
  assign row_prog = rd_vld_q ? rd_prog_q : '0;

  // one decay step of the row just read
  lvl_vec_t          dec_col, tick_col;
  logic [PROG_W-1:0] tick_prog;
  logic              dark;

  always_comb begin
    dark = 1'b1;
    for (int unsigned c = 0; c < CHANNELS; c++) begin
      dec_col[c] = (row_col[c] != '0) ? row_col[c] - 1'b1 : '0;
      if (dec_col[c] != '0) dark = 1'b0;
    end
    tick_col  = row_col;
    tick_prog = row_prog;
    case (row_prog)
      PROG_LINEAR: begin
        tick_col = dec_col;
        if (dark) tick_prog = PROG_CONST;
      end
      PROG_LOOP: tick_col = dark ? row_rel : dec_col;
      default: ;
    endcase
  end

  // set: new reload bytes, colours loaded unless the program is hold
  lvl_vec_t set_rel, set_col;
  for (genvar c = 0; c < CHANNELS; c++) begin : g_set
    if (c < FIELD_CH) begin : g_fld
      assign set_rel[c] = start_q[c];
    end else begin : g_zero
      assign set_rel[c] = '0;
    end
  end
  assign set_col = (prog_q == PROG_HOLD) ? row_col : set_rel;

  logic set_wr;
  assign set_wr = cmd_i.finish && (act_q == ACT_SET) && idx_ok;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  lvl_vec_t          wr_col, wr_rel;
  logic [PROG_W-1:0] wr_prog;

  assign wr_en   = wb_q | set_wr;
  assign wr_addr = wb_q ? wb_addr_q : led_addr;
  assign wr_col  = wb_q ? tick_col  : set_col;
  assign wr_rel  = wb_q ? row_rel   : set_rel;
  assign wr_prog = wb_q ? tick_prog : prog_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      color_mem[wr_addr]  <= wr_col;
      reload_mem[wr_addr] <= wr_rel;
      prog_mem[wr_addr]   <= wr_prog;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
    end else if (wr_en) begin
      row_vld_q[wr_addr] <= 1'b1;
    end
  end

  // result of the named led after the step
  lvl_vec_t                       res_col;
  logic [PROG_W-1:0]              res_prog;
  logic [FIELD_CH-1:0][LVL_W-1:0] res_ch;

  assign res_col  = set_wr ? set_col : row_col;
  assign res_prog = set_wr ? prog_q  : row_prog;

  for (genvar c = 0; c < FIELD_CH; c++) begin : g_res
    if (c < CHANNELS) begin : g_used
      assign res_ch[c] = idx_ok ? res_col[c] : '0;
    end else begin : g_none
      assign res_ch[c] = '0;
    end
  end

  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      red_now_o     <= res_ch[0];
      green_now_o   <= res_ch[1];
      blue_now_o    <= res_ch[2];
      program_now_o <= idx_ok ? res_prog : '0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign stat_o.item_tick = (action_i == ACT_TICK);
  assign stat_o.cnt_last  = (cnt_q == AW'(LED_COUNT - 1));
  assign stat_o.out_free  = ~out_valid_q | out_ready_i;

endmodule : lfpe_dp

`default_nettype wire

@@ hdl/led_fade_program_engine.sv @@
// led_fade_program_engine: top level, joins the controller and the datapath.
// Depends on lfpe_pkg, lfpe_in_if, lfpe_out_if, lfpe_ctrl and lfpe_dp.
//
// Usage
//   item_i carries one request per transfer: set (store program and reload
//   bytes of one led), tick (advance every led one step) or read. Each item
//   gives exactly one transfer on result_o with the named led's colours and
//   program after the step; an index beyond the led count reports zeros.
//   Set and read: the item is captured, the named led's row is read, and the
//   result register is loaded; the next item is taken only after that.
//   Tick: the sweep reads and writes back one led per cycle through the single
//   memory port pair, then the named led is read for the result.
//   One item is in work at a time; item_i.ready is high only between items.
//   A finished result sits in the output register while the next item is
//   taken; if result_o is stalled, the engine holds in its last step until
//   the register is free, and result_o payload holds while valid is high and ready is low.
//   Reset (rst_ni low, asynchronous) clears every led to dark and constant
//   at once through per-led valid bits; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module led_fade_program_engine #(
  parameter int unsigned LED_COUNT = lfpe_pkg::LED_COUNT_DEF,
  parameter int unsigned CHANNELS  = lfpe_pkg::CHANNELS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  lfpe_in_if.sink     item_i,
  lfpe_out_if.source  result_o
);
  import lfpe_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  lfpe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (item_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lfpe_dp #(
    .LED_COUNT (LED_COUNT),
    .CHANNELS  (CHANNELS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .action_i      (item_i.action),
    .led_index_i   (item_i.led_index),
    .program_req_i (item_i.program_req),
    .red_start_i   (item_i.red_start),
    .green_start_i (item_i.green_start),
    .blue_start_i  (item_i.blue_start),
    .out_valid_o   (result_o.valid),
    .out_ready_i   (result_o.ready),
    .red_now_o     (result_o.red_now),
    .green_now_o   (result_o.green_now),
    .blue_now_o    (result_o.blue_now),
    .program_now_o (result_o.program_now)
  );

endmodule : led_fade_program_engine

`default_nettype wire

@@ hdl/lfpe_checker.sv @@
// lfpe_checker: port-level assertions on the led fade program engine,
// attached to the top level by the bind at the end. Depends on lfpe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lfpe_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_i,
  input wire logic                          out_valid_i,
  input wire logic                          out_ready_i,
  input wire logic [lfpe_pkg::LVL_W-1:0]    red_now_i,
  input wire logic [lfpe_pkg::LVL_W-1:0]    green_now_i,
  input wire logic [lfpe_pkg::LVL_W-1:0]    blue_now_i,
  input wire logic [lfpe_pkg::PROG_W-1:0]   program_now_i
);
  import lfpe_pkg::*;

  logic in_xfer, out_xfer;
  assign in_xfer  = in_valid_i & in_ready_i;
  assign out_xfer = out_valid_i & out_ready_i;

  // items taken whose result has not been transferred yet
  logic [1:0] pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_xfer && !out_xfer) begin
      pend_q <= pend_q + 1'b1;
    end else if (out_xfer && !in_xfer) begin
      pend_q <= pend_q - 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(red_now_i) && $stable(green_now_i)
      && $stable(blue_now_i) && $stable(program_now_i))
    else $error("result payload changed while stalled");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 2'd0)
    else $error("result shown with no item outstanding");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_i)
    else $error("engine ready again right after taking an item");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 2'd2)
    else $error("more than two items outstanding");

endmodule : lfpe_checker

bind led_fade_program_engine lfpe_checker u_lfpe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (item_i.valid),
  .in_ready_i    (item_i.ready),
  .out_valid_i   (result_o.valid),
  .out_ready_i   (result_o.ready),
  .red_now_i     (result_o.red_now),
  .green_now_i   (result_o.green_now),
  .blue_now_i    (result_o.blue_now),
  .program_now_i (result_o.program_now)
);

`default_nettype wire

@@ tb/led_fade_program_engine_tb.sv @@
`timescale 1ns / 1ps
// led_fade_program_engine_tb: self-checking bench that drives set, tick, read and spare-code items
// with random pauses on both sides. Depends on lfpe_pkg, lfpe_in_if, lfpe_out_if and the engine.

module led_fade_program_engine_tb;
  import lfpe_pkg::*;

  localparam int unsigned LEDS  = LED_COUNT_DEF;
  localparam int unsigned CHANS = CHANNELS_DEF;
  // the action field can carry a code that has no enum member; the engine treats it as a read
  localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

  localparam int unsigned RANDOM_ITEMS = 1200;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned CYCLE_LIMIT  = 600000;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [IDX_W-1:0]  led;
    logic [PROG_W-1:0] prog;
    logic [LVL_W-1:0]  red;
    logic [LVL_W-1:0]  green;
    logic [LVL_W-1:0]  blue;
  } fade_req_t;

  typedef struct packed {
    logic [LVL_W-1:0]  red;
    logic [LVL_W-1:0]  green;
    logic [LVL_W-1:0]  blue;
    logic [PROG_W-1:0] prog;
  } led_view_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  lfpe_in_if  item_bus ();
  lfpe_out_if result_bus ();

  logic      in_valid  = 1'b0;
  fade_req_t in_req    = '0;
  logic      out_ready = 1'b0;

  assign item_bus.valid       = in_valid;
  assign item_bus.action      = in_req.action;
  assign item_bus.led_index   = in_req.led;
  assign item_bus.program_req = in_req.prog;
  assign item_bus.red_start   = in_req.red;
  assign item_bus.green_start = in_req.green;
  assign item_bus.blue_start  = in_req.blue;
  assign result_bus.ready     = out_ready;

  led_fade_program_engine dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_bus),
    .result_o (result_bus)
  );

  always #5 clk_i = ~clk_i;

  // predicted engine state
  logic [LVL_W-1:0] level_mem  [LEDS][CHANS];
  logic [LVL_W-1:0] reload_mem [LEDS][CHANS];
  prog_e            prog_mem   [LEDS];

  fade_req_t   request_q [$];
  led_view_t   view_q [$];
  int unsigned tx_wait      = 0;
  int unsigned tx_run       = 0;
  int unsigned rx_wait      = 0;
  int unsigned rx_run       = 0;
  int unsigned results_seen = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;

  // one decay step; true when every channel ends dark
  function automatic bit decay_led(int unsigned led);
    bit dark;
    dark = 1'b1;
    for (int c = 0; c < CHANS; c++) begin
      if (level_mem[led][c] != '0) begin
        level_mem[led][c] = level_mem[led][c] - 1'b1;
        if (level_mem[led][c] != '0) dark = 1'b0;
      end
    end
    return dark;
  endfunction

  function automatic led_view_t apply_request(fade_req_t r);
    led_view_t        v;
    logic [LVL_W-1:0] start [FIELD_CH];
    start[0] = r.red;
    start[1] = r.green;
    start[2] = r.blue;
    case (r.action)
      ACT_SET: begin
        prog_mem[r.led] = prog_e'(r.prog);
        for (int c = 0; c < CHANS; c++) reload_mem[r.led][c] = start[c];
        if (prog_e'(r.prog) != PROG_HOLD) begin
          for (int c = 0; c < CHANS; c++) level_mem[r.led][c] = reload_mem[r.led][c];
        end
      end
      ACT_TICK: begin
        for (int n = 0; n < LEDS; n++) begin
          case (prog_mem[n])
            PROG_LINEAR: if (decay_led(n)) prog_mem[n] = PROG_CONST;
            PROG_LOOP: begin
              if (decay_led(n)) begin
                for (int c = 0; c < CHANS; c++) level_mem[n][c] = reload_mem[n][c];
              end
            end
            default: ;
          endcase
        end
      end
      default: ; // read and the spare code leave the state alone
    endcase
    v.red   = level_mem[r.led][0];
    v.green = level_mem[r.led][1];
    v.blue  = level_mem[r.led][2];
    v.prog  = prog_mem[r.led];
    return v;
  endfunction

  // cycles to wait before the next transfer, with runs of back-to-back transfers
  function automatic int unsigned draw_pause(inout int unsigned run_left);
    if (run_left != 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      run_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  function automatic logic [LVL_W-1:0] random_level();
    // mostly low levels so that decays run out and loops reload
    if ($urandom_range(0, 4) == 0) return LVL_W'($urandom_range(0, 255));
    return LVL_W'($urandom_range(0, 6));
  endfunction

  function automatic fade_req_t random_request();
    fade_req_t   r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 35)      r.action = ACT_SET;
    else if (pick < 75) r.action = ACT_TICK;
    else if (pick < 95) r.action = ACT_READ;
    else                r.action = ACT_SPARE;
    // a few hot leds keep decaying state visible in the results
    if ($urandom_range(0, 9) < 6) r.led = IDX_W'($urandom_range(0, 7));
    else                          r.led = IDX_W'($urandom_range(0, LEDS - 1));
    r.prog  = PROG_W'($urandom_range(0, 3));
    r.red   = random_level();
    r.green = random_level();
    r.blue  = random_level();
    return r;
  endfunction

  task automatic queue_req(logic [ACT_W-1:0] action, int unsigned led, prog_e prog,
                           logic [LVL_W-1:0] red, logic [LVL_W-1:0] green,
                           logic [LVL_W-1:0] blue);
    fade_req_t r;
    r.action = action;
    r.led    = IDX_W'(led);
    r.prog   = prog;
    r.red    = red;
    r.green  = green;
    r.blue   = blue;
    request_q.push_back(r);
  endtask

  // sender: predicts on every transfer, then offers the next item after its pause
  always @(posedge clk_i) begin : tx_side
    fade_req_t next_req;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      tx_wait = 0;
      tx_run  = 0;
    end else begin
      if (in_valid && item_bus.ready) begin
        view_q.push_back(apply_request(in_req));
        tx_wait = draw_pause(tx_run);
      end
      if (!in_valid || item_bus.ready) begin
        if (tx_wait == 0 && request_q.size() != 0) begin
          next_req = request_q.pop_front();
          in_req   <= next_req;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
          if (tx_wait != 0) tx_wait--;
        end
      end
    end
  end

  // receiver: checks each result against the oldest prediction
  always @(posedge clk_i) begin : rx_side
    led_view_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      rx_wait = 0;
      rx_run  = 0;
    end else begin
      if (out_ready && result_bus.valid) begin
        if (view_q.size() == 0) begin
          $error("result transfer with no item outstanding");
          mismatch_cnt++;
        end else begin
          want = view_q.pop_front();
          if (result_bus.red_now !== want.red) begin
            $error("red_now: expected %0d, actual %0d", want.red, result_bus.red_now);
            mismatch_cnt++;
          end
          if (result_bus.green_now !== want.green) begin
            $error("green_now: expected %0d, actual %0d", want.green, result_bus.green_now);
            mismatch_cnt++;
          end
          if (result_bus.blue_now !== want.blue) begin
            $error("blue_now: expected %0d, actual %0d", want.blue, result_bus.blue_now);
            mismatch_cnt++;
          end
          if (result_bus.program_now !== want.prog) begin
            $error("program_now: expected %0d, actual %0d", want.prog,
                   result_bus.program_now);
            mismatch_cnt++;
          end
        end
        results_seen++;
        rx_wait = draw_pause(rx_run);
        // long back-pressure so the engine fills up and stalls its input
        if (results_seen == 300 || results_seen == 800) rx_wait = LONG_HOLD;
      end
      if (rx_wait != 0) begin
        out_ready <= 1'b0;
        rx_wait--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    for (int n = 0; n < LEDS; n++) begin
      prog_mem[n] = PROG_CONST;
      for (int c = 0; c < CHANS; c++) begin
        level_mem[n][c]  = '0;
        reload_mem[n][c] = '0;
      end
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset state at both ends of the index range
    queue_req(ACT_READ, 0, PROG_CONST, 8'h00, 8'h00, 8'h00);
    queue_req(ACT_READ, 63, PROG_HOLD, 8'hff, 8'hff, 8'hff);
    queue_req(ACT_SET, 0, PROG_CONST, 8'hff, 8'hff, 8'hff);
    queue_req(ACT_SET, 63, PROG_LINEAR, 8'h01, 8'h02, 8'h00);
    queue_req(ACT_SET, 5, PROG_LOOP, 8'h01, 8'h00, 8'h01);
    // decaying leds that start dark
    queue_req(ACT_SET, 10, PROG_LINEAR, 8'h00, 8'h00, 8'h00);
    queue_req(ACT_SET, 11, PROG_LOOP, 8'h00, 8'h00, 8'h00);
    // hold stores reload bytes but keeps the colours
    queue_req(ACT_SET, 12, PROG_HOLD, 8'haa, 8'h55, 8'hff);
    queue_req(ACT_SET, 0, PROG_HOLD, 8'h00, 8'h00, 8'h00);
    queue_req(ACT_SET, 42, PROG_LINEAR, 8'hff, 8'hff, 8'hff);
    queue_req(ACT_TICK, 63, PROG_CONST, 8'h00, 8'h00, 8'h00);
    queue_req(ACT_TICK, 5, PROG_HOLD, 8'hff, 8'hff, 8'hff);
    queue_req(ACT_READ, 10, PROG_CONST, 8'h00, 8'h00, 8'h00);
    queue_req(ACT_READ, 11, PROG_CONST, 8'h00, 8'h00, 8'h00);
    queue_req(ACT_SPARE, 5, PROG_LOOP, 8'h12, 8'h34, 8'h56);
    queue_req(ACT_READ, 12, PROG_CONST, 8'h00, 8'h00, 8'h00);
    queue_req(ACT_READ, 0, PROG_CONST, 8'h00, 8'h00, 8'h00);
    queue_req(ACT_TICK, 42, PROG_LINEAR, 8'h80, 8'h40, 8'h01);
    queue_req(ACT_SET, 12, PROG_LOOP, 8'h02, 8'h01, 8'h00);
    queue_req(ACT_TICK, 12, PROG_CONST, 8'h00, 8'h00, 8'h00);
    queue_req(ACT_TICK, 12, PROG_CONST, 8'h00, 8'h00, 8'h00);
    queue_req(ACT_SPARE, 63, PROG_CONST, 8'h00, 8'h00, 8'h00);

    // random items are queued only once every outstanding result is back
    do @(posedge clk_i); while (request_q.size() != 0 || in_valid || view_q.size() != 0);

    for (int n = 0; n < RANDOM_ITEMS; n++) request_q.push_back(random_request());

    do @(posedge clk_i); while (request_q.size() != 0 || in_valid || view_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/lfpe_pkg.sv
hdl/lfpe_if.sv
hdl/lfpe_ctrl.sv
hdl/lfpe_dp.sv
hdl/led_fade_program_engine.sv
hdl/lfpe_checker.sv
tb/led_fade_program_engine_tb.sv
